/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tick task flag checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset as disable condition
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error(msg);

// Same check, clocked on clk with reset arst_n
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLKD(lbl, clk, arst_n, prop, msg)

`endif

/* hw/rtl/mrtf_pkg.sv */
// ----------------------------------------------------------------------------
// Tick task flags package
// Widths, request codes, reset periods and shared structs.
// ----------------------------------------------------------------------------
package mrtf_pkg;

	localparam int CHANNELS     = 8;
	localparam int CH_W         = 3;
	localparam int PERIOD_W     = 8;
	localparam int OP_W         = 2;
	localparam int IDX_W        = 4;
	localparam int CFG_IDX_W    = 4;
	localparam int TASK_COUNT_DEFAULT = 8;

	// request codes; code 3 does nothing
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// period registers after reset, also the counters' reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RESET [CHANNELS] = '{
		8'd2, 8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd208, 8'd208
	};

	// request entering the flag core
	typedef struct packed {
		logic            valid;
		logic [OP_W-1:0] op;
		logic [IDX_W-1:0] task_index;
	} cmd_t;

	// configuration write
	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [PERIOD_W-1:0]  data;
	} cfg_wr_t;

	// result of one request
	typedef struct packed {
		logic                run_flag;
		logic [CHANNELS-1:0] pending_mask;
	} rsp_t;

endpackage

/* hw/rtl/mrtf_cmd_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying op and task_index.
// ----------------------------------------------------------------------------
interface mrtf_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [mrtf_pkg::OP_W-1:0]   op;
	logic [mrtf_pkg::IDX_W-1:0]  task_index;

	modport source (output valid, output op, output task_index, input ready);
	modport sink   (input valid, input op, input task_index, output ready);
endinterface

/* hw/rtl/mrtf_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying run_flag and pending_mask.
// ----------------------------------------------------------------------------
interface mrtf_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           run_flag;
	logic [mrtf_pkg::CHANNELS-1:0]  pending_mask;

	modport source (output valid, output run_flag, output pending_mask, input ready);
	modport sink   (input valid, input run_flag, input pending_mask, output ready);
endinterface

/* hw/rtl/mrtf_core.sv */
// ----------------------------------------------------------------------------
// Tick task flag core
// Period registers, down-counters and pending flags; executes one request.
// ----------------------------------------------------------------------------
module mrtf_core #(
	parameter int TASK_COUNT = mrtf_pkg::TASK_COUNT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrtf_pkg::cfg_wr_t cfg,
	input  mrtf_pkg::cmd_t    cmd,
	output mrtf_pkg::rsp_t    rsp
);

	localparam int CH = mrtf_pkg::CHANNELS;
	localparam int PW = mrtf_pkg::PERIOD_W;
	localparam int IW = mrtf_pkg::IDX_W;
	localparam logic [CH-1:0] ACTIVE_MASK = CH'((64'd1 << TASK_COUNT) - 64'd1);
	localparam logic [IW-1:0] TASK_LIMIT  = IW'(TASK_COUNT);

	logic [PW-1:0] period_q [CH];
	logic [PW-1:0] cnt_q    [CH];
	logic [CH-1:0] flag_q;
	logic [CH-1:0] flag_d;
	logic [CH-1:0] cfg_hit;
	logic [PW-1:0] period_wr;
	logic          idx_ok;
	logic          do_tick;
	logic          do_query;
	logic          do_clear;
	logic [mrtf_pkg::CH_W-1:0] sel;

	// request decode
	assign idx_ok   = cmd.task_index < TASK_LIMIT;
	assign sel      = cmd.task_index[mrtf_pkg::CH_W-1:0];
	assign do_tick  = cmd.valid && (cmd.op == mrtf_pkg::OP_TICK);
	assign do_query = cmd.valid && (cmd.op == mrtf_pkg::OP_QUERY) && idx_ok;
	assign do_clear = cmd.valid && (cmd.op == mrtf_pkg::OP_CLEAR) && idx_ok;

	// config write: zero period is stored as one
	assign period_wr = (cfg.data == '0) ? PW'(1) : cfg.data;
	always_comb begin
		for (int i = 0; i < CH; i++) begin
			cfg_hit[i] = cfg.en && (cfg.index == mrtf_pkg::CFG_IDX_W'(i));
		end
	end

	// next pending flags: expiring counters set, clear drops one
	always_comb begin
		flag_d = flag_q;
		if (do_tick) begin
			for (int i = 0; i < CH; i++) begin
				if (ACTIVE_MASK[i] && (cnt_q[i] == PW'(1))) begin
					flag_d[i] = 1'b1;
				end
			end
		end
		if (do_clear) begin
			flag_d[sel] = 1'b0;
		end
	end

	// result: queried flag before the step, mask after it
	assign rsp.run_flag     = do_query ? flag_q[sel] : 1'b0;
	assign rsp.pending_mask = flag_d & ACTIVE_MASK;

	// counters and periods
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH; i++) begin
				period_q[i] <= mrtf_pkg::PERIOD_RESET[i];
				cnt_q[i]    <= mrtf_pkg::PERIOD_RESET[i];
			end
			flag_q <= '0;
		end else begin
			for (int i = 0; i < CH; i++) begin
				if (cfg_hit[i]) begin
					period_q[i] <= period_wr;
					cnt_q[i]    <= period_wr;
				end else if (do_tick && ACTIVE_MASK[i]) begin
					cnt_q[i] <= (cnt_q[i] == PW'(1)) ? period_q[i] : cnt_q[i] - PW'(1);
				end
			end
			flag_q <= flag_d;
		end
	end

endmodule

/* hw/rtl/multi_rate_tick_task_flags.sv */
// A request is held in the input register; its result is held in the output register.
// Throughput: one request per cycle while results are taken, the input register refilling.
// The output register decouples the sides, so a waiting result does not stall the next intake
// until the input register is also full.
// Reset (arst_n low): periods and counters load their reset periods, flags and valids clear.
module multi_rate_tick_task_flags #(
	parameter int TASK_COUNT = mrtf_pkg::TASK_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mrtf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mrtf_pkg::PERIOD_W-1:0]    cfg_data,
	mrtf_cmd_if.sink                         cmd,
	mrtf_rsp_if.source                       rsp
);

	logic                         valid_s1;
	logic [mrtf_pkg::OP_W-1:0]    op_s1;
	logic [mrtf_pkg::IDX_W-1:0]   idx_s1;
	logic                         valid_s2;
	mrtf_pkg::rsp_t               rsp_s2;
	logic                         advance;
	mrtf_pkg::cmd_t               core_cmd;
	mrtf_pkg::cfg_wr_t            core_cfg;
	mrtf_pkg::rsp_t               core_rsp;

	// flow control: stage 1 moves when the output register is free or drained
	assign advance   = !valid_s2 || rsp.ready;
	assign cmd.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1  <= cmd.op;
			idx_s1 <= cmd.task_index;
		end
	end

	// core executes the request as it leaves stage 1
	assign core_cmd = '{valid: valid_s1 && advance, op: op_s1, task_index: idx_s1};
	assign core_cfg = '{en: cfg_wr_en, index: cfg_index, data: cfg_data};

	mrtf_core #(
		.TASK_COUNT (TASK_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (core_cfg),
		.cmd    (core_cmd),
		.rsp    (core_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.run_flag     = rsp_s2.run_flag;
	assign rsp.pending_mask = rsp_s2.pending_mask;

endmodule

/* hw/rtl/mrtf_checker.sv */
// ----------------------------------------------------------------------------
// Tick task flags port checker
// Watches the top level's channels and binds to every instance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrtf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_run_flag,
	input logic [mrtf_pkg::CHANNELS-1:0] rsp_pending_mask
);

	// a result not taken stays offered
	`ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped before taken")

	// a stalled result keeps its payload
	`ASSERT_STD(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_pending_mask) && $stable(rsp_run_flag), "stalled response payload changed")

	// an accepted request leads to a result offered from the output register
	`ASSERT_STD(a_cmd_to_rsp, cmd_valid && cmd_ready |=> ##1 rsp_valid, "accepted request produced no response")

	// with an empty output the block always takes requests
	`ASSERT_STD(a_ready_when_empty, !rsp_valid |-> cmd_ready, "request stalled with empty output")

	// a set queried flag shows in the mask
	`ASSERT_STD(a_flag_in_mask, rsp_valid && rsp_run_flag |-> rsp_pending_mask != '0, "run flag set with empty mask")

endmodule

bind multi_rate_tick_task_flags mrtf_checker u_mrtf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_run_flag     (rsp.run_flag),
	.rsp_pending_mask (rsp.pending_mask)
);

/* verif/mrtf_flag_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick task flag scoreboard
// Watches the request, response and period write ports, keeps its own copy
// of the counters, periods and pending flags, and compares every response
// in order against the predicted one.
// ----------------------------------------------------------------------------
module mrtf_flag_scoreboard import mrtf_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data,
	mrtf_cmd_if                  cmd,
	mrtf_rsp_if                  rsp,
	output int                   mismatches,
	output int                   checked,
	output int                   pending
);

	// shadow state
	logic [PERIOD_W-1:0] period_q  [CHANNELS];
	logic [PERIOD_W-1:0] countdown [CHANNELS];
	logic [CHANNELS-1:0] flags;
	rsp_t                flag_results_q [$];

	// apply one request to the shadow state, return the response it earns
	function automatic rsp_t advance_task_flags(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] idx);
		rsp_t                r;
		logic [PERIOD_W-1:0] c;
		r.run_flag = 1'b0;
		case (op)
			OP_TICK: begin
				for (int i = 0; i < TASK_COUNT; i++) begin
					c = countdown[i] - PERIOD_W'(1);
					if (c == '0) begin
						c = period_q[i];
						flags[i] = 1'b1;
					end
					countdown[i] = c;
				end
			end
			OP_QUERY: begin
				if (idx < TASK_COUNT)
					r.run_flag = flags[idx[CH_W-1:0]];
			end
			OP_CLEAR: begin
				if (idx < TASK_COUNT)
					flags[idx[CH_W-1:0]] = 1'b0;
			end
			default: ;
		endcase
		r.pending_mask = flags;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t: response %0d %s: expected %0h, got %0h",
				$realtime, checked, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   = PERIOD_RESET;
			countdown  = PERIOD_RESET;
			flags      = '0;
			flag_results_q.delete();
			mismatches = 0;
			checked    = 0;
			pending    = 0;
		end else begin
			// period write: zero is stored as one, out-of-range index ignored
			if (cfg_wr_en && cfg_index < CHANNELS) begin
				period_q[cfg_index[CH_W-1:0]]  = (cfg_data == '0) ? PERIOD_W'(1) : cfg_data;
				countdown[cfg_index[CH_W-1:0]] = period_q[cfg_index[CH_W-1:0]];
			end
			// compare before predicting, so a response in the same cycle as its request is caught
			if (rsp.valid && rsp.ready) begin
				if (flag_results_q.size() == 0) begin
					note_mismatch("arrived with nothing outstanding", 0,
						int'(rsp.pending_mask));
				end else begin
					rsp_t want;
					want = flag_results_q.pop_front();
					if (rsp.run_flag !== want.run_flag)
						note_mismatch("run_flag", int'(want.run_flag), int'(rsp.run_flag));
					if (rsp.pending_mask !== want.pending_mask)
						note_mismatch("pending_mask", int'(want.pending_mask),
							int'(rsp.pending_mask));
				end
				checked++;
			end
			if (cmd.valid && cmd.ready)
				flag_results_q.push_back(advance_task_flags(cmd.op, cmd.task_index));
			pending = flag_results_q.size();
		end
	end

endmodule

/* verif/multi_rate_tick_task_flags_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick task flags testbench
// Drives ticks, queries, clears and unused codes in random bursts under
// several period settings, stalls the response side on its own pattern, and
// leaves checking to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module multi_rate_tick_task_flags_test;
	import mrtf_pkg::*;

	localparam int              TASKS          = TASK_COUNT_DEFAULT;
	localparam logic [OP_W-1:0] OP_NOP         = 2'd3;
	localparam int              TOTAL_REQUESTS = 550;
	localparam int              DRAIN_CYCLES   = 4;
	localparam int              LONG_HOLD      = 60;
	localparam int              CYCLE_LIMIT    = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PERIOD_W-1:0]  cfg_data;

	mrtf_cmd_if cmd ();
	mrtf_rsp_if rsp ();

	int mismatches;
	int checked;
	int pending;
	int hold_requests;
	int burst_left;
	int cycles;
	int sent;
	int cfg_writes;
	int settings_used;
	int op_count [4];

	multi_rate_tick_task_flags #(
		.TASK_COUNT(TASKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.rsp      (rsp)
	);

	mrtf_flag_scoreboard #(
		.TASK_COUNT(TASKS)
	) scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rsp       (rsp),
		.mismatches(mismatches),
		.checked   (checked),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// response side: random modes, plus a long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int hold;
		int seen;
		mode_left = 0;
		seen      = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (seen != hold_requests) begin
				seen = hold_requests;
				rsp.ready <= 1'b0;
				hold = 0;
				while (hold < LONG_HOLD) begin
					@(posedge clk);
					hold++;
				end
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(2, 0);
					mode_left = $urandom_range(64, 8);
				end
				mode_left--;
				case (mode)
					0:       rsp.ready <= 1'b1;
					1:       rsp.ready <= 1'($urandom_range(1, 0));
					default: rsp.ready <= ($urandom_range(3, 0) == 0);
				endcase
			end
		end
	end

	// offer one request; opens a new burst after a random gap when the last one ran out
	task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(5, 0) == 0) ? $urandom_range(24, 8) : $urandom_range(4, 0);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(16, 1);
		end
		cmd.valid      <= 1'b1;
		cmd.op         <= op;
		cmd.task_index <= idx;
		do @(posedge clk); while (!cmd.ready);
		burst_left--;
		sent++;
		op_count[op]++;
	endtask

	// stop offering and wait until every response is back
	task automatic drain_results();
		cmd.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_period(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_writes++;
	endtask

	// rewrite all periods; setting 0 holds the extremes
	task automatic load_periods(input int setting);
		logic [PERIOD_W-1:0] p;
		for (int i = 0; i < CHANNELS; i++) begin
			case (setting % 4)
				0: begin
					case (i)
						0:       p = 8'd0;
						1:       p = 8'd1;
						2:       p = 8'd255;
						3:       p = 8'd2;
						4:       p = 8'd3;
						5:       p = 8'd128;
						6:       p = 8'd7;
						default: p = 8'd1;
					endcase
				end
				1:       p = PERIOD_W'($urandom_range(8, 1));
				2:       p = PERIOD_W'($urandom_range(255, 0));
				default: p = PERIOD_W'($urandom_range(3, 0));
			endcase
			write_period(CFG_IDX_W'(i), p);
		end
		// writes past the last register are dropped by the block
		write_period(CFG_IDX_W'(CHANNELS), PERIOD_W'($urandom_range(255, 0)));
		write_period(CFG_IDX_W'($urandom_range(15, CHANNELS)),
			PERIOD_W'($urandom_range(255, 0)));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic send_random();
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		int               r;
		r = $urandom_range(99, 0);
		if (r < 45)
			op = OP_TICK;
		else if (r < 75)
			op = OP_QUERY;
		else if (r < 95)
			op = OP_CLEAR;
		else
			op = OP_NOP;
		if (op == OP_TICK || $urandom_range(7, 0) == 0)
			idx = IDX_W'($urandom_range(15, 0));
		else
			idx = IDX_W'($urandom_range(TASKS - 1, 0));
		send_request(op, idx);
	endtask

	initial begin
		int phase;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cmd.valid      = 1'b0;
		cmd.op         = OP_TICK;
		cmd.task_index = '0;
		hold_requests  = 0;
		burst_left     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset periods, bad indexes, unused code, first flags
		send_request(OP_QUERY, 4'd0);
		send_request(OP_QUERY, 4'd15);
		send_request(OP_CLEAR, 4'd9);
		send_request(OP_NOP, 4'd5);
		send_request(OP_TICK, 4'd0);
		send_request(OP_TICK, 4'd15);
		send_request(OP_QUERY, 4'd0);
		send_request(OP_QUERY, 4'd8);
		send_request(OP_CLEAR, 4'd8);
		repeat (3) send_request(OP_TICK, 4'd7);
		send_request(OP_QUERY, 4'd1);
		send_request(OP_CLEAR, 4'd0);
		send_request(OP_QUERY, 4'd0);
		send_request(OP_CLEAR, 4'd1);
		send_request(OP_QUERY, 4'd1);
		send_request(OP_NOP, 4'd15);
		send_request(OP_TICK, 4'd10);
		send_request(OP_QUERY, 4'd7);
		send_request(OP_CLEAR, 4'd15);
		send_request(OP_QUERY, 4'd0);

		// random phases, each under a fresh period setting
		phase = 0;
		while (sent < TOTAL_REQUESTS) begin
			drain_results();
			load_periods(phase);
			repeat ($urandom_range(120, 80)) begin
				if (sent < TOTAL_REQUESTS)
					send_random();
				if ($urandom_range(60, 0) == 0)
					drain_results();
			end
			// response side holds off while requests keep coming
			if (phase == 1) begin
				hold_requests++;
				burst_left = 30;
				repeat (24) send_random();
			end
			phase++;
		end
		drain_results();

		$display("covered %0d requests: %0d ticks, %0d queries, %0d clears, %0d unused codes",
			sent, op_count[OP_TICK], op_count[OP_QUERY], op_count[OP_CLEAR], op_count[OP_NOP]);
		$display("%0d period writes over %0d settings, %0d responses compared",
			cfg_writes, settings_used, checked);
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mrtf_pkg.sv
hw/rtl/mrtf_cmd_if.sv
hw/rtl/mrtf_rsp_if.sv
hw/rtl/mrtf_core.sv
hw/rtl/multi_rate_tick_task_flags.sv
hw/rtl/mrtf_checker.sv
verif/mrtf_flag_scoreboard.sv
verif/multi_rate_tick_task_flags_test.sv
